/* hdl/cts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, marker table and byte helpers for the credential text scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

  // history depth and the span a marker may cover (history plus current byte)
  localparam int WINDOW_DEPTH = 12;
  localparam int SPAN_BYTES   = WINDOW_DEPTH + 1;
  localparam int SPAN_BITS    = SPAN_BYTES * 8;
  localparam int MARKER_COUNT = 16;
  localparam int RUN_W        = 6;

  typedef logic [7:0]                   byte_t;
  typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;
  typedef logic [RUN_W-1:0]             run_t;

  localparam run_t  RUN_LEN_RESET = run_t'(32);

  localparam byte_t CHAR_UC_A = 8'h41;
  localparam byte_t CHAR_UC_Z = 8'h5A;
  localparam byte_t CHAR_UC_F = 8'h46;
  localparam byte_t CHAR_LC_A = 8'h61;
  localparam byte_t CHAR_LC_F = 8'h66;
  localparam byte_t CHAR_0    = 8'h30;
  localparam byte_t CHAR_9    = 8'h39;
  localparam byte_t CASE_GAP  = 8'h20;

  // markers right-justified: byte 0 is the final character
  localparam logic [SPAN_BITS-1:0] MARKER_TEXT [MARKER_COUNT] = '{
    SPAN_BITS'("://"),
    SPAN_BITS'("token="),
    SPAN_BITS'("apikey="),
    SPAN_BITS'("api_key="),
    SPAN_BITS'({"access", "_key"}),
    SPAN_BITS'("accesstoken"),
    SPAN_BITS'("auth="),
    SPAN_BITS'("authorization"),
    SPAN_BITS'("signature="),
    SPAN_BITS'("sig="),
    SPAN_BITS'("x-amz-"),
    SPAN_BITS'("bearer "),
    SPAN_BITS'("password="),
    SPAN_BITS'("passwd="),
    SPAN_BITS'("secret="),
    SPAN_BITS'({"session", "_id="})
  };

  localparam logic [3:0] MARKER_LEN [MARKER_COUNT] = '{
    4'd3, 4'd6, 4'd7, 4'd8, 4'd10, 4'd11, 4'd5, 4'd13,
    4'd10, 4'd4, 4'd6, 4'd7, 4'd9, 4'd7, 4'd7, 4'd11
  };

  // ascii lowercase, other bytes untouched
  function automatic byte_t to_lower(input byte_t c);
    return (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? byte_t'(c + CASE_GAP) : c;
  endfunction

  function automatic logic is_hex(input byte_t c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LC_A && c <= CHAR_LC_F) ||
           (c >= CHAR_UC_A && c <= CHAR_UC_F);
  endfunction

endpackage

/* hdl/credential_text_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credential_text_scanner
// Byte-per-transaction string scanner that flags urls, key markers and long
// hex runs, with one verdict per string on its final byte.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// input     in_valid / in_ready    char_code, char_present, last
// output    out_valid / out_ready  looks_like_credential
// config    cfg_write              cfg_data (hex run length)
//
// one byte per cycle sustained unless a final byte waits on a stalled verdict;
// a verdict passes through the input register, then the result register
// the input register keeps taking bytes while a verdict waits, unless it
// holds a final byte that cannot yet move into the result register
// synchronous reset clears the history, run count, flags and sets run length 32
// ----------------------------------------------------------------------------
module credential_text_scanner import cts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       char_present,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       looks_like_credential
);

  // input register
  logic    a_valid;
  byte_t   a_code;
  logic    a_present;
  logic    a_last;

  // string state and configuration
  window_t recent;
  run_t    hex_cnt;
  logic    seen;
  run_t    run_len;

  logic    out_flag;

  logic    a_adv;
  logic    out_free;
  byte_t   low;
  logic    marker_hit;
  run_t    hex_cnt_next;
  logic    seen_next;

  // handshake control
  assign out_free = !out_valid || out_ready;
  assign a_adv    = a_valid && (!a_last || out_free);
  assign in_ready = !a_valid || a_adv;

  assign looks_like_credential = out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_code    <= char_code;
      a_present <= char_present;
      a_last    <= last;
    end
  end

  // marker compare
  assign low = to_lower(a_code);

  cts_match u_match (
    .recent (recent),
    .cur    (low),
    .hit    (marker_hit)
  );

  // hex run count, saturating at the configured length
  always_comb begin
    if (!is_hex(a_code)) begin
      hex_cnt_next = '0;
    end else if (hex_cnt < run_len) begin
      hex_cnt_next = run_t'(hex_cnt + 1'b1);
    end else begin
      hex_cnt_next = hex_cnt;
    end
    seen_next = seen || marker_hit || (hex_cnt_next >= run_len);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= RUN_LEN_RESET;
    end else if (cfg_write) begin
      run_len <= cfg_data;
    end
  end

  // string state update, cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      recent  <= '0;
      hex_cnt <= '0;
      seen    <= 1'b0;
    end else if (a_adv) begin
      if (a_last) begin
        recent  <= '0;
        hex_cnt <= '0;
        seen    <= 1'b0;
      end else if (a_present) begin
        recent  <= {recent[WINDOW_DEPTH-2:0], low};
        hex_cnt <= hex_cnt_next;
        seen    <= seen_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_adv && a_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_last) begin
      out_flag <= a_present ? seen_next : seen;
    end
  end

  // a verdict only ever follows a final byte leaving the input register
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(a_adv && a_last))
    else $error("verdict raised without a final byte");

  // string state is empty after a final byte
  assert property (@(posedge clk) disable iff (rst)
    (a_adv && a_last) |=> (recent == '0 && hex_cnt == '0 && !seen))
    else $error("string state not cleared after final byte");

  // a held final byte blocks the input while the verdict stalls
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_last && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while final byte is blocked");

  // an empty input register always takes a new byte
  assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> in_ready)
    else $error("input stalled with empty input register");

endmodule

/* hdl/cts_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_match
// Compares the byte history plus the current byte against every marker.
// ----------------------------------------------------------------------------
module cts_match import cts_pkg::*; (
  input  window_t recent,
  input  byte_t   cur,
  output logic    hit
);

  logic [SPAN_BYTES-1:0][7:0] span;
  logic [MARKER_COUNT-1:0]    marker_hit;

  // current byte sits at the low end, newest history next
  assign span = {recent, cur};

  // one comparator row per marker, bytes beyond its length ignored
  always_comb begin
    for (int m = 0; m < MARKER_COUNT; m++) begin
      marker_hit[m] = 1'b1;
      for (int k = 0; k < SPAN_BYTES; k++) begin
        if ((k < int'(MARKER_LEN[m])) && (span[k] != MARKER_TEXT[m][k*8 +: 8])) begin
          marker_hit[m] = 1'b0;
        end
      end
    end
  end

  assign hit = |marker_hit;

endmodule
